>>> hw/rtl/json_token_lexer_top_macros.svh
// Assertion macros for the JSON token lexer.
`ifndef JSON_TOKEN_LEXER_TOP_MACROS_SVH
`define JSON_TOKEN_LEXER_TOP_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define JTL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define JTL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/jtl_pkg.sv
// Types and constants shared by the JSON token lexer.
package jtl_pkg;

    localparam int unsigned RUN_DEPTH = 3;

    localparam logic [3:0] KIND_LBRACKET  = 4'd0;
    localparam logic [3:0] KIND_RBRACKET  = 4'd1;
    localparam logic [3:0] KIND_LBRACE    = 4'd2;
    localparam logic [3:0] KIND_RBRACE    = 4'd3;
    localparam logic [3:0] KIND_COLON     = 4'd4;
    localparam logic [3:0] KIND_COMMA     = 4'd5;
    localparam logic [3:0] KIND_STR_START = 4'd6;
    localparam logic [3:0] KIND_STR_CHAR  = 4'd7;
    localparam logic [3:0] KIND_STR_END   = 4'd8;
    localparam logic [3:0] KIND_INTEGER   = 4'd9;
    localparam logic [3:0] KIND_END       = 4'd10;

    localparam logic [7:0] CH_LBRACKET  = 8'h5B;
    localparam logic [7:0] CH_RBRACKET  = 8'h5D;
    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;
    localparam logic [7:0] CH_COLON     = 8'h3A;
    localparam logic [7:0] CH_COMMA     = 8'h2C;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_NINE      = 8'h39;

    localparam logic [30:0] INT_SAT = 31'h7FFF_FFFF;

    typedef enum logic [1:0] {
        MODE_OUT = 2'd0,
        MODE_STR = 2'd1,
        MODE_NUM = 2'd2
    } mode_t;

    typedef struct packed {
        logic [3:0]  token_kind;
        logic [7:0]  char_value;
        logic [30:0] int_value;
        logic        last_of_run;
    } token_word_t;

endpackage

>>> hw/rtl/jtl_stream_if.sv
// Byte input and token output channel interfaces.
interface jtl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       end_of_input;

    modport source (output valid, output byte_value, output end_of_input, input ready);
    modport sink   (input valid, input byte_value, input end_of_input, output ready);
endinterface

interface jtl_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  token_kind;
    logic [7:0]  char_value;
    logic [30:0] int_value;
    logic        last_of_run;

    modport source (output valid, output token_kind, output char_value,
                    output int_value, output last_of_run, input ready);
    modport sink   (input valid, input token_kind, input char_value,
                    input int_value, input last_of_run, output ready);
endinterface

>>> hw/rtl/json_token_lexer_top.sv
// JSON token lexer: byte stream in, token stream out.
//
//  channel  dir  word contents
//  in_ch    in   byte_value, end_of_input
//  out_ch   out  token_kind, char_value, int_value, last_of_run
//
// One byte is taken per cycle while the output accepts tokens; a byte that yields
// more than one token holds the input until the last of its run is taken by the single token output port.
// A byte passes through the input register, then the token run buffer, whose first word drives the output.
// rst_n clears lexer state, input valid and run count; data regs are not reset.
// Input register and token run buffer decouple the two sides under stalls.
`include "json_token_lexer_top_macros.svh"

module json_token_lexer_top (
    input  logic      clk,
    input  logic      rst_n,
    jtl_in_if.sink    in_ch,
    jtl_out_if.source out_ch
);
    import jtl_pkg::*;

    logic         in_valid_reg;
    logic [7:0]   byte_reg;
    logic         eoi_reg;

    mode_t        mode_reg,  mode_next;
    logic         bs_reg,    bs_next;
    logic [30:0]  acc_reg,   acc_next;

    token_word_t  run_reg  [RUN_DEPTH];
    token_word_t  run_next [RUN_DEPTH];
    token_word_t  new_run  [RUN_DEPTH];
    logic [1:0]   cnt_reg, cnt_next;
    logic [1:0]   new_cnt;

    logic         pop;
    logic         buf_free;
    logic         adv;

    logic         is_digit;
    logic [30:0]  digit_val;
    logic [34:0]  acc_mul;
    logic         ob_emit;
    logic [3:0]   ob_kind;
    token_word_t  ob_word;

    assign pop      = (cnt_reg != 2'd0) && out_ch.ready;
    assign buf_free = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && out_ch.ready);
    assign adv      = in_valid_reg && buf_free;
    assign in_ch.ready = !in_valid_reg || buf_free;

    assign out_ch.valid       = (cnt_reg != 2'd0);
    assign out_ch.token_kind  = run_reg[0].token_kind;
    assign out_ch.char_value  = run_reg[0].char_value;
    assign out_ch.int_value   = run_reg[0].int_value;
    assign out_ch.last_of_run = run_reg[0].last_of_run;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            in_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            byte_reg <= in_ch.byte_value;
            eoi_reg  <= in_ch.end_of_input;
        end
    end

    // byte classification outside a token
    assign is_digit  = (byte_reg >= CH_ZERO) && (byte_reg <= CH_NINE);
    assign digit_val = {23'd0, byte_reg - CH_ZERO};
    assign acc_mul   = {1'b0, acc_reg, 3'd0} + {3'd0, acc_reg, 1'b0} + {4'd0, digit_val};

    always_comb
    begin
        ob_emit = 1'b1;
        ob_kind = KIND_LBRACKET;
        unique case (byte_reg)
            CH_LBRACKET: ob_kind = KIND_LBRACKET;
            CH_RBRACKET: ob_kind = KIND_RBRACKET;
            CH_LBRACE:   ob_kind = KIND_LBRACE;
            CH_RBRACE:   ob_kind = KIND_RBRACE;
            CH_COLON:    ob_kind = KIND_COLON;
            CH_COMMA:    ob_kind = KIND_COMMA;
            CH_QUOTE:    ob_kind = KIND_STR_START;
            default:     ob_emit = 1'b0;
        endcase
        ob_word = '{token_kind: ob_kind, char_value: 8'd0, int_value: 31'd0,
                    last_of_run: 1'b0};
    end

    // lexer next state and token run
    always_comb
    begin
        token_word_t blank;
        blank     = '{token_kind: KIND_END, char_value: 8'd0, int_value: 31'd0,
                      last_of_run: 1'b0};
        mode_next = mode_reg;
        bs_next   = bs_reg;
        acc_next  = acc_reg;
        new_cnt   = 2'd0;
        for (int i = 0; i < RUN_DEPTH; i++)
        begin
            new_run[i] = blank;
        end

        if (eoi_reg)
        begin
            mode_next = MODE_OUT;
            bs_next   = 1'b0;
            acc_next  = 31'd0;
            unique case (mode_reg)
                MODE_STR:
                begin
                    if (bs_reg)
                    begin
                        new_run[0].token_kind = KIND_STR_CHAR;
                        new_run[0].char_value = CH_BACKSLASH;
                        new_run[1].token_kind = KIND_STR_END;
                        new_run[2].token_kind = KIND_END;
                        new_cnt = 2'd3;
                    end
                    else
                    begin
                        new_run[0].token_kind = KIND_STR_END;
                        new_run[1].token_kind = KIND_END;
                        new_cnt = 2'd2;
                    end
                end
                MODE_NUM:
                begin
                    new_run[0].token_kind = KIND_INTEGER;
                    new_run[0].int_value  = acc_reg;
                    new_run[1].token_kind = KIND_END;
                    new_cnt = 2'd2;
                end
                default:
                begin
                    new_run[0].token_kind = KIND_END;
                    new_cnt = 2'd1;
                end
            endcase
        end
        else if (mode_reg == MODE_STR)
        begin
            if (bs_reg)
            begin
                new_run[0].token_kind = KIND_STR_CHAR;
                if (byte_reg == CH_QUOTE)
                begin
                    new_run[0].char_value = CH_QUOTE;
                    bs_next = 1'b0;
                    new_cnt = 2'd1;
                end
                else if (byte_reg == CH_BACKSLASH)
                begin
                    new_run[0].char_value = CH_BACKSLASH;
                    new_cnt = 2'd1;
                end
                else
                begin
                    new_run[0].char_value = CH_BACKSLASH;
                    new_run[1].token_kind = KIND_STR_CHAR;
                    new_run[1].char_value = byte_reg;
                    bs_next = 1'b0;
                    new_cnt = 2'd2;
                end
            end
            else if (byte_reg == CH_QUOTE)
            begin
                new_run[0].token_kind = KIND_STR_END;
                mode_next = MODE_OUT;
                new_cnt = 2'd1;
            end
            else if (byte_reg == CH_BACKSLASH)
            begin
                bs_next = 1'b1;
            end
            else
            begin
                new_run[0].token_kind = KIND_STR_CHAR;
                new_run[0].char_value = byte_reg;
                new_cnt = 2'd1;
            end
        end
        else if ((mode_reg == MODE_NUM) && is_digit)
        begin
            acc_next = (acc_mul > {4'd0, INT_SAT}) ? INT_SAT : acc_mul[30:0];
        end
        else
        begin
            // number end (if any) first, then the byte as outside a token
            if (mode_reg == MODE_NUM)
            begin
                new_run[0].token_kind = KIND_INTEGER;
                new_run[0].int_value  = acc_reg;
                new_cnt = 2'd1;
            end
            mode_next = MODE_OUT;
            acc_next  = 31'd0;
            if (ob_emit)
            begin
                new_run[new_cnt] = ob_word;
                new_cnt = new_cnt + 2'd1;
                if (byte_reg == CH_QUOTE)
                begin
                    mode_next = MODE_STR;
                    bs_next   = 1'b0;
                end
            end
            else if (is_digit)
            begin
                mode_next = MODE_NUM;
                acc_next  = digit_val;
            end
        end

        for (int i = 0; i < RUN_DEPTH; i++)
        begin
            new_run[i].last_of_run = (new_cnt == 2'(i + 1));
        end
    end

    // lexer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_OUT;
            bs_reg   <= 1'b0;
            acc_reg  <= 31'd0;
        end
        else if (adv)
        begin
            mode_reg <= mode_next;
            bs_reg   <= bs_next;
            acc_reg  <= acc_next;
        end
    end

    // token run buffer: load a whole run, drain one word a cycle while the output is ready
    always_comb
    begin
        cnt_next = cnt_reg;
        for (int i = 0; i < RUN_DEPTH; i++)
        begin
            run_next[i] = run_reg[i];
        end
        if (adv)
        begin
            cnt_next = new_cnt;
            for (int i = 0; i < RUN_DEPTH; i++)
            begin
                run_next[i] = new_run[i];
            end
        end
        else if (pop)
        begin
            cnt_next = cnt_reg - 2'd1;
            for (int i = 0; i < RUN_DEPTH - 1; i++)
            begin
                run_next[i] = run_reg[i + 1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < RUN_DEPTH; i++)
        begin
            run_reg[i] <= run_next[i];
        end
    end

    `JTL_ASSERT_NOW(a_last_on_final, out_ch.valid && (cnt_reg == 2'd1), out_ch.last_of_run, "final word of run lacks last_of_run")
    `JTL_ASSERT_NOW(a_no_early_last, out_ch.valid && (cnt_reg != 2'd1), !out_ch.last_of_run, "last_of_run before end of run")
    `JTL_ASSERT_NEXT(a_eoi_clears, adv && eoi_reg, (mode_reg == MODE_OUT) && !bs_reg && (acc_reg == 31'd0), "state not cleared after end of input")
    `JTL_ASSERT_NOW(a_char_zero, out_ch.valid && (out_ch.token_kind != KIND_STR_CHAR), out_ch.char_value == 8'd0, "char_value set on non-character token")
endmodule
